>>> hdl/transpose_search_table_core_macros.svh
// Assertion macros shared by the search table RTL.
`ifndef TRANSPOSE_SEARCH_TABLE_CORE_MACROS_SVH
`define TRANSPOSE_SEARCH_TABLE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge out of reset.
`define TST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be seen at a clock edge out of reset.
`define TST_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TST_ASSERT(lbl, prop, msg)
`define TST_NEVER(lbl, cond, msg)
`endif
`endif

>>> hdl/tst_pkg.sv
// Types and constants of the transpose search table.
package tst_pkg;

    localparam int ENTRIES_W = 11;
    localparam int INDEX_W   = 10;
    localparam int WORD_W    = 32;

    // Operation codes carried in the opcode field.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic                     opcode;
        logic [INDEX_W-1:0]       entry_index;
        logic signed [WORD_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] hit_index;
    } out_item_t;

endpackage

>>> hdl/tst_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module tst_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, updated only when re is high.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/transpose_search_table_core.sv
// Top level of the self-organising search table with the transpose heuristic.
// A write item's result is shown in the cycle after the item; busy stays low.
// A search reads one entry per cycle from the table RAM, up to the saturated
// entries_in_use; a hit at an index above zero goes through the swap states
// ST_SWAP_LO and ST_SWAP_HI before its result is shown.
// One item at a time; the receiver cannot stall. Reset clears control and entries_in_use.
`include "transpose_search_table_core_macros.svh"

module transpose_search_table_core
    import tst_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  in_item_t             cmd,
    output logic                 done,
    output out_item_t            result,
    input  logic                 cfg_we,
    input  logic [ENTRIES_W-1:0] cfg_wdata
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_N = $clog2(TABLE_DEPTH + 1);
    localparam int CW    = (CNT_N > ENTRIES_W) ? CNT_N : ENTRIES_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_SCAN    = 4'b0010,
        ST_SWAP_LO = 4'b0100,
        ST_SWAP_HI = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [ENTRIES_W-1:0]   entries_reg;
    logic [CW-1:0]          limit_reg, limit_next;
    logic [CW-1:0]          issue_reg, issue_next;
    logic [CW-1:0]          cmp_reg, cmp_next;
    logic                   rvalid_reg, rvalid_next;
    logic [WORD_W-1:0]      key_reg, key_next;
    logic [WORD_W-1:0]      prev_reg, prev_next;
    logic                   done_reg, done_next;
    out_item_t              result_reg, result_next;

    logic                   accept;
    logic [CW-1:0]          entries_ext;
    logic [CW-1:0]          wr_pos;
    logic                   hit_now;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [WORD_W-1:0]      ram_wdata;
    logic                   ram_re;
    logic [WORD_W-1:0]      ram_rdata;

    assign accept      = start && (state_reg == ST_IDLE);
    assign entries_ext = CW'(entries_reg);
    assign wr_pos      = CW'(cmd.entry_index);
    assign hit_now     = rvalid_reg && (ram_rdata == key_reg);
    assign ram_re      = (state_reg == ST_SCAN) && (issue_reg < limit_reg);

    // Table storage.
    tst_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    function automatic logic [IDX_W-1:0] cmp_prev_addr(input logic [CW-1:0] pos);
        logic [CW-1:0] dec;
        dec = pos - 1'b1;
        return dec[IDX_W-1:0];
    endfunction

    // Sequencer: accept, pipelined scan, swap in ST_SWAP_LO and ST_SWAP_HI.
    always_comb
    begin
        state_next  = state_reg;
        limit_next  = limit_reg;
        issue_next  = issue_reg;
        cmp_next    = cmp_reg;
        rvalid_next = 1'b0;
        key_next    = key_reg;
        prev_next   = prev_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        ram_we      = 1'b0;
        ram_waddr   = IDX_W'(cmd.entry_index);
        ram_wdata   = cmd.value;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.opcode == OP_WRITE)
                    begin
                        // Writes beyond the table are dropped.
                        ram_we                = (wr_pos < DEPTH_C);
                        done_next             = 1'b1;
                        result_next.found     = 1'b0;
                        result_next.hit_index = '0;
                    end
                    else
                    begin
                        key_next   = cmd.value;
                        limit_next = (entries_ext > DEPTH_C) ? DEPTH_C : entries_ext;
                        issue_next = '0;
                        cmp_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (ram_re)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                rvalid_next = ram_re && !hit_now;
                if (hit_now)
                begin
                    result_next.found     = 1'b1;
                    result_next.hit_index = cmp_reg[INDEX_W-1:0];
                    if (cmp_reg != '0)
                    begin
                        state_next = ST_SWAP_LO;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (rvalid_reg)
                begin
                    prev_next = ram_rdata;
                    cmp_next  = cmp_reg + 1'b1;
                end
                else if (!ram_re)
                begin
                    // Nothing in flight and nothing left to read: a miss.
                    result_next.found     = 1'b0;
                    result_next.hit_index = '0;
                    done_next             = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            ST_SWAP_LO:
            begin
                // The matching entry moves one place towards the front.
                ram_we     = 1'b1;
                ram_waddr  = cmp_prev_addr(cmp_reg);
                ram_wdata  = key_reg;
                state_next = ST_SWAP_HI;
            end
            ST_SWAP_HI:
            begin
                ram_we     = 1'b1;
                ram_waddr  = cmp_reg[IDX_W-1:0];
                ram_wdata  = prev_reg;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rvalid_reg  <= 1'b0;
            done_reg    <= 1'b0;
            entries_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rvalid_reg <= rvalid_next;
            done_reg   <= done_next;
            if (cfg_we)
            begin
                entries_reg <= cfg_wdata;
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        limit_reg  <= limit_next;
        issue_reg  <= issue_next;
        cmp_reg    <= cmp_next;
        key_reg    <= key_next;
        prev_reg   <= prev_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Checks on the sequencer.
    `TST_ASSERT(a_done_idle, done_reg |-> (state_reg == ST_IDLE), "result shown while busy")
    `TST_NEVER(a_no_write_in_scan, ram_we && (state_reg == ST_SCAN), "table written during a scan")
    `TST_ASSERT(a_scan_order, (state_reg == ST_SCAN) |-> (cmp_reg <= issue_reg), "compare ahead of reads")
    `TST_ASSERT(a_search_starts, (accept && (cmd.opcode == OP_SEARCH)) |=> (state_reg == ST_SCAN), "search not started")
    `TST_ASSERT(a_swap_nonzero, (state_reg == ST_SWAP_LO) |-> (cmp_reg != '0), "swap at index zero")

endmodule

>>> test/transpose_search_table_core_test.sv
// Self-checking testbench for the transpose search table core.
`timescale 1ns / 1ps

module transpose_search_table_core_test;
    import tst_pkg::*;

    localparam int     TABLE_DEPTH   = 1024;
    localparam int     CLK_HALF      = 4;
    localparam int     IDLE_PCT      = 28;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     TAIL_CYCLES   = 16;
    localparam int     PHASE_ITEMS   = 58;
    localparam int     PHASE_COUNT   = 10;
    localparam longint CYCLE_LIMIT   = 3_000_000;

    // One row of the directed part: either a register write or an item.
    typedef struct {
        bit                   set_cfg;
        logic [ENTRIES_W-1:0] cfg_value;
        in_item_t             item;
        bit                   typed;
        out_item_t            want;
    } step_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    in_item_t             cmd;
    logic                 done;
    out_item_t            result;
    logic                 cfg_we;
    logic [ENTRIES_W-1:0] cfg_wdata;

    // Shadow copy of the table contents and of the entry count.
    bit signed [WORD_W-1:0] entry_mem [TABLE_DEPTH];
    bit                     entry_written [TABLE_DEPTH];
    logic [ENTRIES_W-1:0]   entries_model;

    out_item_t              awaited_results [$];
    step_t                  directed_steps [$];
    int                     phase_entries [PHASE_COUNT] =
        '{3, 1, 16, 64, 2, 300, 1024, 2047, 1000, 40};
    int                     fail_count;
    int                     write_count;
    int                     search_count;
    int                     hit_count;
    int                     swap_count;
    int                     gap_pct;
    logic signed [WORD_W-1:0] last_key;
    longint                 cycle_count;

    transpose_search_table_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Number of entries a search looks at, saturated to the table depth.
    function automatic int scan_limit();
        return (entries_model > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_model);
    endfunction

    // Applies one item to the shadow table and returns the result it must give.
    function automatic out_item_t table_response(input in_item_t c);
        out_item_t              r;
        int                     lim;
        bit signed [WORD_W-1:0] held;
        r = '0;
        if (c.opcode == OP_WRITE)
        begin
            write_count++;
            if (c.entry_index < TABLE_DEPTH)
            begin
                entry_mem[c.entry_index]     = c.value;
                entry_written[c.entry_index] = 1'b1;
            end
            return r;
        end
        search_count++;
        lim = scan_limit();
        for (int i = 0; i < lim; i++)
        begin
            if (entry_mem[i] == c.value)
            begin
                r.found     = 1'b1;
                r.hit_index = INDEX_W'(i);
                hit_count++;
                // A hit past the front trades places with its neighbour.
                if (i > 0)
                begin
                    held             = entry_mem[i - 1];
                    entry_mem[i - 1] = entry_mem[i];
                    entry_mem[i]     = held;
                    swap_count++;
                end
                break;
            end
        end
        return r;
    endfunction

    // First unwritten entry that a search for this key would read, or -1.
    function automatic int first_gap(input logic signed [WORD_W-1:0] key);
        int lim;
        lim = scan_limit();
        for (int i = 0; i < lim; i++)
        begin
            if (!entry_written[i])
                return i;
            if (entry_mem[i] == key)
                return -1;
        end
        return -1;
    endfunction

    // Values biased towards the extremes and a small pool, so duplicates occur.
    function automatic logic signed [WORD_W-1:0] pick_value();
        int v;
        v = $urandom_range(0, 9);
        unique case (v)
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            4, 5, 6: return int'($urandom_range(0, 7)) - 4;
            default: return $urandom();
        endcase
    endfunction

    // Random item: mostly searches for keys that sit in the scanned part.
    function automatic in_item_t random_command();
        in_item_t c;
        int       lim;
        int       r;
        int       gap;
        lim = scan_limit();
        c = '0;
        c.entry_index = INDEX_W'($urandom());
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            c.opcode = OP_WRITE;
            c.value  = pick_value();
            r = $urandom_range(0, 99);
            if (r < 10 || lim == 0)
                c.entry_index = INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
            else if (r < 13)
                c.entry_index = '0;
            else if (r < 15)
                c.entry_index = INDEX_W'(TABLE_DEPTH - 1);
            else
                c.entry_index = INDEX_W'($urandom_range(0, lim - 1));
            return c;
        end
        c.opcode = OP_SEARCH;
        r = $urandom_range(0, 99);
        if (r < 55 && lim > 0)
            c.value = entry_mem[$urandom_range(0, lim - 1)];
        else if (r < 70)
            c.value = last_key;
        else if (r < 80)
            c.value = pick_value();
        else
            c.value = $urandom();
        last_key = c.value;
        // A search must never reach an entry that was never written.
        gap = first_gap(c.value);
        if (gap >= 0)
        begin
            c.opcode      = OP_WRITE;
            c.entry_index = INDEX_W'(gap);
            c.value       = pick_value();
        end
        return c;
    endfunction

    function automatic step_t write_step(input int idx, input logic signed [WORD_W-1:0] v);
        step_t s;
        s = '{default: '0};
        s.item  = '{OP_WRITE, INDEX_W'(idx), v};
        s.typed = 1'b1;
        return s;
    endfunction

    function automatic step_t search_step(input logic signed [WORD_W-1:0] key,
                                          input bit typed, input bit hit, input int idx);
        step_t s;
        s = '{default: '0};
        s.item  = '{OP_SEARCH, '0, key};
        s.typed = typed;
        s.want  = '{hit, INDEX_W'(idx)};
        return s;
    endfunction

    function automatic step_t config_step(input int n);
        step_t s;
        s = '{default: '0};
        s.set_cfg   = 1'b1;
        s.cfg_value = ENTRIES_W'(n);
        return s;
    endfunction

    // Presents one item until it is taken, then records its expected result.
    task automatic send_command(input in_item_t c, input bit typed, input out_item_t want);
        bit        taken;
        out_item_t predicted;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < gap_pct)
                start <= 1'b0;
            else
            begin
                start <= 1'b1;
                cmd   <= c;
            end
            @(posedge clk);
            taken = start && !busy;
        end
        predicted = table_response(c);
        awaited_results.push_back(typed ? want : predicted);
    endtask

    // Writes the entry count once the block has gone quiet.
    task automatic set_entries(input logic [ENTRIES_W-1:0] n);
        @(negedge clk);
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        // By the time its result has gone out, a swap has finished writing.
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(negedge clk);
        cfg_we <= 1'b0;
        entries_model = n;
    endtask

    // Compare each result with the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with no item waiting: found=%0b hit_index=%0d",
                       result.found, result.hit_index);
                fail_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (result.found !== want.found)
                begin
                    $error("found: expected %0b, got %0b", want.found, result.found);
                    fail_count++;
                end
                if (result.hit_index !== want.hit_index)
                begin
                    $error("hit_index: expected %0d, got %0d",
                           want.hit_index, result.hit_index);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Reset, directed rows, random phases and the final verdict.
    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        cmd           = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        entries_model = '0;
        gap_pct       = IDLE_PCT;
        last_key      = '0;
        fail_count    = 0;
        write_count   = 0;
        search_count  = 0;
        hit_count     = 0;
        swap_count    = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            entry_mem[i]     = '0;
            entry_written[i] = 1'b0;
        end

        directed_steps = '{
            search_step(32'sd0, 1'b1, 1'b0, 0),
            write_step(0, 32'sh8000_0000),
            write_step(1, 32'sh7FFF_FFFF),
            write_step(2, 32'sd0),
            write_step(3, -32'sd1),
            write_step(TABLE_DEPTH - 1, 32'sh1234_5678),
            write_step(4, 32'sh7FFF_FFFF),
            search_step(32'sh7FFF_FFFF, 1'b1, 1'b0, 0),
            config_step(5),
            search_step(32'sh8000_0000, 1'b1, 1'b1, 0),
            search_step(32'sh7FFF_FFFF, 1'b1, 1'b1, 1),
            search_step(32'sh7FFF_FFFF, 1'b1, 1'b1, 0),
            search_step(-32'sd1, 1'b1, 1'b1, 3),
            search_step(-32'sd1, 1'b0, 1'b0, 0),
            search_step(32'sd0, 1'b0, 1'b0, 0),
            search_step(32'sd5, 1'b1, 1'b0, 0),
            config_step(1),
            search_step(32'sh7FFF_FFFF, 1'b1, 1'b1, 0),
            search_step(-32'sd1, 1'b1, 1'b0, 0),
            config_step(0),
            search_step(32'sh7FFF_FFFF, 1'b1, 1'b0, 0)
        };

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows: extremes, first of two copies, moves and misses.
        foreach (directed_steps[i])
        begin
            if (directed_steps[i].set_cfg)
                set_entries(directed_steps[i].cfg_value);
            else
                send_command(directed_steps[i].item, directed_steps[i].typed,
                             directed_steps[i].want);
        end

        // Random phases, each with its own entry count.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            set_entries(ENTRIES_W'(phase_entries[p]));
            // One phase runs with no idle cycles at all.
            gap_pct = (p == 3) ? 0 : IDLE_PCT;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_command(random_command(), 1'b0, '0);
        end

        @(negedge clk);
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d writes and %0d searches: %0d hits, %0d of which moved forward.",
                 write_count, search_count, hit_count, swap_count);
        $display("Entry counts went from none in use to beyond the table depth.");
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
